// ===== src/mtpl_pkg.sv =====
// Shared types, codes and constants of the trie prefix lookup block.
`timescale 1ns / 1ps
package mtpl_pkg;

    localparam int NODES_DEF    = 65536;
    localparam int HEADROOM_DEF = 40;

    localparam logic MODE_INS = 1'b0;
    localparam logic MODE_LKP = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [3:0] SLOT_B3   = 4'd0;
    localparam logic [3:0] SLOT_B2   = 4'd8;
    localparam logic [3:0] SLOT_B1   = 4'd12;
    localparam logic [3:0] SLOT_FULL = 4'd14;

    localparam logic [5:0] MAX_LEN = 6'd32;
    localparam logic [3:0] LEVELS  = 4'd8;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic start;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic finish;
    } stat_t;

endpackage

// ===== src/mtpl_if.sv =====
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps
interface mtpl_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [7:0]  port_in;

    modport source (output valid, mode, address, prefix_len, port_in, input ready);
    modport sink (input valid, mode, address, prefix_len, port_in, output ready);
endinterface

interface mtpl_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       hit;
    logic [7:0] port_out;

    modport source (output valid, status, hit, port_out, input ready);
    modport sink (input valid, status, hit, port_out, output ready);
endinterface

// ===== src/multibit_trie_prefix_lookup_top.sv =====
// Top level of the 4-bit-stride trie longest-prefix-match table.
// The walk visits the trie level by level (up to 9 levels on lookup, up to 9 on insert),
// as each node row read feeds the next address, then the result is handed off.
// Items are taken one at a time: a new item is accepted only after the result is taken.
// Reset: clears control state, then a clearing pass over every node row zeroes both
// node stores; no item is accepted until it ends.
`timescale 1ns / 1ps
module multibit_trie_prefix_lookup_top
    import mtpl_pkg::*;
#(
    parameter int NODES    = NODES_DEF,
    parameter int HEADROOM = HEADROOM_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    mtpl_req_if.sink  req,
    mtpl_rsp_if.source rsp
);

    cmd_t  cmd;
    stat_t stat;

    mtpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mtpl_datapath #(
        .NODES    (NODES),
        .HEADROOM (HEADROOM)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (req.mode),
        .address    (req.address),
        .prefix_len (req.prefix_len),
        .port_in    (req.port_in),
        .status     (rsp.status),
        .hit        (rsp.hit),
        .port_out   (rsp.port_out)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request taken while a result waits");

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (rsp.status == ST_DONE))
        else $error("hit reported with failing status");

    a_port_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.port_out != 8'd0) |-> rsp.hit)
        else $error("port reported without hit");

    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (!rsp.valid && !req.ready))
        else $error("item finished in its accept cycle");

endmodule

// ===== src/mtpl_ctrl.sv =====
// Controller state machine: clearing pass, accept, trie walk, result hand-off.
`timescale 1ns / 1ps
module mtpl_ctrl
    import mtpl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.finish)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/mtpl_datapath.sv =====
// Datapath: node stores, walk registers, slot selection and result registers.
`timescale 1ns / 1ps
module mtpl_datapath
    import mtpl_pkg::*;
#(
    parameter int NODES    = NODES_DEF,
    parameter int HEADROOM = HEADROOM_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        mode,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_len,
    input  logic [7:0]  port_in,
    output logic [1:0]  status,
    output logic        hit,
    output logic [7:0]  port_out
);

    localparam int NW = $clog2(NODES);
    localparam int CW = NW + 8;

    logic [15:0][NW-1:0] child_mem [NODES];
    logic [14:0][7:0]    port_mem  [NODES];

    logic [15:0][NW-1:0] child_rd_reg;
    logic [14:0][7:0]    port_rd_reg;

    logic          mode_reg;
    logic [31:0]   addr_reg;
    logic [5:0]    len_reg;
    logic [7:0]    port_reg;
    logic [NW-1:0] cur_reg, cur_next;
    logic [3:0]    lvl_reg, lvl_next;
    logic [7:0]    best_reg, best_next;
    logic [NW-1:0] used_reg, used_next;
    logic [NW-1:0] clr_reg;
    logic [1:0]    status_reg;
    logic          hit_reg;
    logic [7:0]    port_out_reg;

    logic [3:0]          nib;
    logic [NW-1:0]       child;
    logic [7:0]          v;
    logic [3:0]          k;
    logic [1:0]          fin_status;
    logic                child_we, port_we;
    logic [15:0][NW-1:0] child_wdata;
    logic [14:0][7:0]    port_wdata;
    logic [NW-1:0]       rd_addr, wr_addr;
    logic                full;
    logic                no_room;

    assign nib     = addr_reg[{~lvl_reg[2:0], 2'b00} +: 4];
    assign child   = child_rd_reg[nib];
    assign full    = (CW'(used_reg) + CW'(HEADROOM)) > CW'(NODES);
    assign no_room = (CW'(used_reg) + CW'(1)) >= CW'(NODES);

    always_comb
    begin
        case (len_reg[1:0])
            2'd3:    k = SLOT_B3 + {1'b0, nib[3:1]};
            2'd2:    k = SLOT_B2 + {2'b00, nib[3:2]};
            2'd1:    k = SLOT_B1 + {3'b000, nib[3]};
            default: k = SLOT_FULL;
        endcase
    end

    always_comb
    begin
        v = port_rd_reg[SLOT_B3 + {1'b0, nib[3:1]}];
        if (v == 8'd0)
        begin
            v = port_rd_reg[SLOT_B2 + {2'b00, nib[3:2]}];
        end
        if (v == 8'd0)
        begin
            v = port_rd_reg[SLOT_B1 + {3'b000, nib[3]}];
        end
    end

    always_comb
    begin
        stat.clear_done = (clr_reg == NW'(NODES - 1));
        stat.finish     = 1'b0;
        fin_status      = ST_DONE;
        cur_next        = cur_reg;
        lvl_next        = lvl_reg;
        best_next       = best_reg;
        used_next       = used_reg;
        child_we        = 1'b0;
        port_we         = 1'b0;
        child_wdata     = child_rd_reg;
        port_wdata      = port_rd_reg;
        if (cmd.start)
        begin
            cur_next  = '0;
            lvl_next  = '0;
            best_next = '0;
        end
        else if (cmd.step)
        begin
            if (mode_reg == MODE_LKP)
            begin
                if (port_rd_reg[SLOT_FULL] != 8'd0)
                begin
                    best_next = port_rd_reg[SLOT_FULL];
                end
                if (lvl_reg == LEVELS)
                begin
                    stat.finish = 1'b1;
                end
                else
                begin
                    if (v != 8'd0)
                    begin
                        best_next = v;
                    end
                    if (child == '0)
                    begin
                        stat.finish = 1'b1;
                    end
                    else
                    begin
                        cur_next = child;
                        lvl_next = lvl_reg + 4'd1;
                    end
                end
            end
            else if (lvl_reg == 4'd0 && full)
            begin
                stat.finish = 1'b1;
                fin_status  = ST_FULL;
            end
            else if (lvl_reg < len_reg[5:2])
            begin
                lvl_next = lvl_reg + 4'd1;
                if (child != '0)
                begin
                    cur_next = child;
                end
                else if (no_room)
                begin
                    stat.finish = 1'b1;
                    fin_status  = ST_FULL;
                end
                else
                begin
                    used_next        = used_reg + NW'(1);
                    child_wdata[nib] = used_reg + NW'(1);
                    child_we         = 1'b1;
                    cur_next         = used_reg + NW'(1);
                end
            end
            else
            begin
                stat.finish = 1'b1;
                if (port_rd_reg[k] != 8'd0)
                begin
                    fin_status = ST_DUP;
                end
                else
                begin
                    port_wdata[k] = port_reg + 8'd1;
                    port_we       = 1'b1;
                end
            end
        end
    end

    assign rd_addr = cur_next;
    assign wr_addr = cmd.clear_en ? clr_reg : cur_reg;

    always_ff @(posedge clk)
    begin
        child_rd_reg <= child_mem[rd_addr];
        port_rd_reg  <= port_mem[rd_addr];
        if (cmd.clear_en || child_we)
        begin
            child_mem[wr_addr] <= cmd.clear_en ? '0 : child_wdata;
        end
        if (cmd.clear_en || port_we)
        begin
            port_mem[wr_addr] <= cmd.clear_en ? '0 : port_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            clr_reg  <= '0;
            cur_reg  <= '0;
            lvl_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            cur_reg  <= cur_next;
            lvl_reg  <= lvl_next;
            if (cmd.clear_en && !stat.clear_done)
            begin
                clr_reg <= clr_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        if (cmd.start)
        begin
            mode_reg <= mode;
            addr_reg <= address;
            len_reg  <= (prefix_len > MAX_LEN) ? MAX_LEN : prefix_len;
            port_reg <= port_in;
        end
        if (stat.finish)
        begin
            status_reg <= fin_status;
            if (mode_reg == MODE_LKP && best_next != 8'd0)
            begin
                hit_reg      <= 1'b1;
                port_out_reg <= best_next - 8'd1;
            end
            else
            begin
                hit_reg      <= 1'b0;
                port_out_reg <= 8'd0;
            end
        end
    end

    assign status   = status_reg;
    assign hit      = hit_reg;
    assign port_out = port_out_reg;

endmodule

// ===== bench/tb_multibit_trie_prefix_lookup_top.sv =====
// Self-checking bench for the trie prefix lookup block: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_multibit_trie_prefix_lookup_top;
    import mtpl_pkg::*;

    localparam int TB_NODES    = 1024;
    localparam int TB_HEADROOM = 8;
    localparam int RAND_ITEMS  = 800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int GAP_MAX     = 18;

    typedef struct {
        logic [1:0] status;
        logic       hit;
        logic [7:0] port_out;
    } route_res_t;

    typedef struct {
        logic        mode;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [7:0]  port_in;
        bit          typed;
        route_res_t  res;
    } route_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   errors = 0;
    bit   calm = 1'b0;

    mtpl_req_if req ();
    mtpl_rsp_if rsp ();

    multibit_trie_prefix_lookup_top #(.NODES(TB_NODES), .HEADROOM(TB_HEADROOM)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** multibit_trie_prefix_lookup_top: FAILED **");
            $finish;
        end
    end

    int unsigned child_map[int unsigned];
    byte unsigned slot_map[int unsigned];
    int unsigned  trie_nodes = 0;
    route_res_t   route_q[$];

    function automatic int unsigned child_at(int unsigned node, int unsigned nib);
        int unsigned key;
        key = node * 16 + nib;
        return child_map.exists(key) ? child_map[key] : 0;
    endfunction

    function automatic byte unsigned slot_at(int unsigned node, int unsigned k);
        int unsigned key;
        key = node * 15 + k;
        return slot_map.exists(key) ? slot_map[key] : 0;
    endfunction

    function automatic route_res_t route_predict(logic m, logic [31:0] a, logic [5:0] l,
                                                 logic [7:0] p);
        route_res_t   r;
        int unsigned  cur, len, nib, nxt, k, rem;
        byte unsigned best, v;
        r.status = ST_DONE;
        r.hit = 1'b0;
        r.port_out = 8'd0;
        cur = 0;
        if (m == MODE_INS)
        begin
            len = (l > MAX_LEN) ? 32'(MAX_LEN) : 32'(l);
            if (trie_nodes + TB_HEADROOM > TB_NODES)
            begin
                r.status = ST_FULL;
                return r;
            end
            for (int lvl = 0; lvl < len / 4; lvl++)
            begin
                nib = (a >> (28 - 4 * lvl)) & 15;
                if (child_at(cur, nib) == 0)
                begin
                    if (trie_nodes + 1 >= TB_NODES)
                    begin
                        r.status = ST_FULL;
                        return r;
                    end
                    trie_nodes++;
                    child_map[cur * 16 + nib] = trie_nodes;
                end
                cur = child_at(cur, nib);
            end
            rem = len % 4;
            if (rem == 3)      k = SLOT_B3 + ((a >> (32 - len)) & 7);
            else if (rem == 2) k = SLOT_B2 + ((a >> (32 - len)) & 3);
            else if (rem == 1) k = SLOT_B1 + ((a >> (32 - len)) & 1);
            else               k = SLOT_FULL;
            if (slot_at(cur, k) != 0)
            begin
                r.status = ST_DUP;
                return r;
            end
            slot_map[cur * 15 + k] = 8'((p + 1) & 8'hFF);
            return r;
        end
        best = slot_at(0, SLOT_FULL);
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            nib = (a >> (28 - 4 * lvl)) & 15;
            v = slot_at(cur, SLOT_B3 + (nib >> 1));
            if (v == 0) v = slot_at(cur, SLOT_B2 + (nib >> 2));
            if (v == 0) v = slot_at(cur, SLOT_B1 + (nib >> 3));
            if (v != 0) best = v;
            nxt = child_at(cur, nib);
            if (nxt == 0 || nxt >= TB_NODES) break;
            cur = nxt;
            v = slot_at(cur, SLOT_FULL);
            if (v != 0) best = v;
        end
        if (best != 0)
        begin
            r.hit = 1'b1;
            r.port_out = 8'(best - 1);
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, field, got, want);
        errors++;
    endtask

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    task automatic send_item(route_row_t row);
        int         gap;
        route_res_t r;
        gap = draw_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.mode       <= row.mode;
        req.address    <= row.address;
        req.prefix_len <= row.prefix_len;
        req.port_in    <= row.port_in;
        do @(posedge clk); while (!req.ready);
        r = route_predict(row.mode, row.address, row.prefix_len, row.port_in);
        route_q.push_back(row.typed ? row.res : r);
    endtask

    function automatic route_row_t mk(logic m, logic [31:0] a, logic [5:0] l, logic [7:0] p,
                                      bit t = 0, logic [1:0] s = ST_DONE, logic h = 0,
                                      logic [7:0] po = 0);
        route_row_t row;
        row.mode = m;
        row.address = a;
        row.prefix_len = l;
        row.port_in = p;
        row.typed = t;
        row.res.status = s;
        row.res.hit = h;
        row.res.port_out = po;
        return row;
    endfunction

    route_row_t directed[$];
    logic [31:0] pool[8];

    initial
    begin
        route_row_t row;
        int sel;
        req.valid = 1'b0;
        req.mode = MODE_LKP;
        req.address = '0;
        req.prefix_len = '0;
        req.port_in = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        directed = '{
            mk(MODE_LKP, 32'h0000_0000, 6'd0,  8'd0,   1, ST_DONE, 0, 0),
            mk(MODE_LKP, 32'hFFFF_FFFF, 6'd63, 8'd255, 1, ST_DONE, 0, 0),
            mk(MODE_INS, 32'h0000_0000, 6'd0,  8'd5,   1, ST_DONE, 0, 0),
            mk(MODE_LKP, 32'h1234_5678, 6'd0,  8'd0,   1, ST_DONE, 1, 5),
            mk(MODE_INS, 32'hFFFF_FFFF, 6'd0,  8'd7,   1, ST_DUP,  0, 0),
            mk(MODE_INS, 32'hFFFF_FFFF, 6'd32, 8'd254, 1, ST_DONE, 0, 0),
            mk(MODE_LKP, 32'hFFFF_FFFF, 6'd0,  8'd0,   1, ST_DONE, 1, 254),
            mk(MODE_INS, 32'hFFFF_FFFF, 6'd32, 8'd1,   1, ST_DUP,  0, 0),
            mk(MODE_INS, 32'hA000_0000, 6'd3,  8'd9),
            mk(MODE_INS, 32'h8000_0000, 6'd1,  8'd0),
            mk(MODE_INS, 32'h4000_0000, 6'd2,  8'd3),
            mk(MODE_INS, 32'h1234_0000, 6'd63, 8'd1),
            mk(MODE_INS, 32'h1234_0000, 6'd40, 8'd2),
            mk(MODE_INS, 32'h5500_0000, 6'd8,  8'd255),
            mk(MODE_LKP, 32'h5500_0000, 6'd0,  8'd0),
            mk(MODE_LKP, 32'hA5A5_A5A5, 6'd0,  8'd0),
            mk(MODE_LKP, 32'h8FFF_FFFF, 6'd0,  8'd0),
            mk(MODE_LKP, 32'h4000_0001, 6'd0,  8'd0),
            mk(MODE_LKP, 32'h1234_0000, 6'd0,  8'd0),
            mk(MODE_INS, 32'h1230_0000, 6'd13, 8'd77),
            mk(MODE_INS, 32'h1238_0000, 6'd14, 8'd78),
            mk(MODE_LKP, 32'h1239_0000, 6'd0,  8'd0),
            mk(MODE_LKP, 32'h1234_FFFF, 6'd0,  8'd0)
        };
        foreach (directed[i]) send_item(directed[i]);

        foreach (pool[i]) pool[i] = $urandom;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                row = mk(MODE_INS, pool[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(4, 31)),
                         6'(($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                        : $urandom_range(0, 32)),
                         8'($urandom_range(0, 255)));
            end
            else if (sel < 85)
                row = mk(MODE_LKP, pool[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(0, 31)),
                         6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
            else
                row = mk(MODE_LKP, $urandom, 6'($urandom_range(0, 63)),
                         8'($urandom_range(0, 255)));
            send_item(row);
        end
        req.valid <= 1'b0;
        wait (route_q.size() == 0);
        repeat (30) @(posedge clk);
        if (errors == 0 && route_q.size() == 0)
            $display("** multibit_trie_prefix_lookup_top: PASSED **");
        else
            $display("** multibit_trie_prefix_lookup_top: FAILED **");
        $finish;
    end

    initial
    begin
        int stall;
        route_res_t want;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
            if (route_q.size() == 0)
            begin
                $display("unexpected item at cycle %0d", cycles);
                errors++;
            end
            else
            begin
                want = route_q.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.hit !== want.hit)
                    report_mismatch("hit", rsp.hit, want.hit);
                if (rsp.port_out !== want.port_out)
                    report_mismatch("port_out", rsp.port_out, want.port_out);
            end
        end
    end
endmodule
